@@ hdl/sdb_pkg.sv @@
// Shared types and constants of the stereo DC-blocking biquad.
package sdb_pkg;

    localparam int COEF_W      = 24;
    localparam int COEF_FRAC   = 22;
    localparam int SCALE_W     = 16;
    localparam int SCALE_SHIFT = 14;
    localparam int NUM_COEFS   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CHANS   = 2;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [CFG_IDX_W-1:0] {
        CF_B0,
        CF_B1,
        CF_B2,
        CF_A1,
        CF_A2
    } t_coef_idx;

    localparam t_coef COEF_RESET [NUM_COEFS] = '{
        t_coef'(4152260),
        t_coef'(-8304520),
        t_coef'(4152260),
        t_coef'(-8304098),
        t_coef'(4110637)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_ACC,
        ST_ROUND,
        ST_SCALE,
        ST_FINAL
    } t_state;

endpackage

@@ hdl/sdb_in_if.sv @@
// Input channel of the biquad: valid, ready and one sample beat.
interface sdb_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import sdb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [SCALE_W-1:0]            out_scale;

    modport source (output valid, output channel, output sample_in, output out_scale,
                    input ready);
    modport sink   (input valid, input channel, input sample_in, input out_scale,
                    output ready);
endinterface

@@ hdl/sdb_out_if.sv @@
// Output channel of the biquad: valid, ready and one result beat.
interface sdb_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

@@ hdl/sdb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module sdb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/stereo_dc_block_biquad.sv @@
// Top level of the stereo DC-blocking biquad in direct form I.
//
// The next beat is accepted in the cycle after the result is loaded, so a new
// sample is taken only once the last result is loaded, which needs the output
// side to keep up. The filter multiplier forms the five filter products one
// per cycle. Before it come the idle state, in which the beat is accepted, and
// the history read. After it come the states for the last accumulation,
// rounding, output scaling and the final saturation. The per-channel history
// lives in a two-entry RAM; a valid bit per channel makes an unwritten entry
// read as zero after reset. A finished result waits in its own register, so a
// new beat is taken while it is still pending.
module stereo_dc_block_biquad #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sdb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sdb_pkg::COEF_W-1:0]    i_cfg_data,
    sdb_in_if.sink                        i_in,
    sdb_out_if.source                     o_out
);
    import sdb_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = COEF_W + SB;
    localparam int ACC_W  = PROD_W + 3;
    localparam int YS_W   = ACC_W - COEF_FRAC;
    localparam int OP_W   = SB + SCALE_W + 1;
    localparam int OS_W   = OP_W - SCALE_SHIFT;
    localparam int HIST_W = 4 * SB;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [OP_W-1:0]  OP_HALF  = OP_W'(1) <<< (SCALE_SHIFT - 1);
    localparam logic signed [SB-1:0]    SAT_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]    SAT_MIN  = {1'b1, {(SB-1){1'b0}}};

    t_state r_state;
    t_state n_state;

    t_coef     r_coef [NUM_COEFS];
    t_coef_idx r_tap;

    logic                     r_ch;
    logic [SCALE_W-1:0]       r_scale;
    logic signed [SB-1:0]     r_x;
    logic signed [SB-1:0]     r_x1;
    logic signed [SB-1:0]     r_x2;
    logic signed [SB-1:0]     r_y1;
    logic signed [SB-1:0]     r_y2;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SB-1:0]     r_y;
    logic signed [OP_W-1:0]   r_oprod;

    logic                     r_out_vld;
    logic                     r_out_ch;
    logic signed [SB-1:0]     r_out_sample;

    logic [NUM_CHANS-1:0]     r_hist_vld;
    logic                     r_rd_vld;

    logic                     in_ready;
    logic                     in_accept;
    logic                     ram_we;
    logic                     out_load;
    logic                     acc_add;

    logic [HIST_W-1:0]        ram_rdata;
    logic [HIST_W-1:0]        ram_wdata;

    logic signed [SB-1:0]     mac_opnd;
    logic                     mac_neg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [YS_W-1:0]   y_shift;
    logic signed [SB-1:0]     y_sat;
    logic signed [OP_W-1:0]   op_rnd;
    logic signed [OS_W-1:0]   o_shift;
    logic signed [SB-1:0]     o_sat;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_MAC;
            ST_MAC: begin
                if (r_tap == CF_A2) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:   n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_FINAL;
            ST_FINAL: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        acc_add  = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_READ:  ;
            ST_MAC:   acc_add  = (r_tap != CF_B0);
            ST_ACC:   acc_add  = 1'b1;
            ST_ROUND: ;
            ST_SCALE: ram_we   = 1'b1;
            ST_FINAL: out_load = !r_out_vld || o_out.ready;
            default:  ;
        endcase
    end

    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= COEF_RESET[i];
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CF_B0:   r_coef[CF_B0] <= i_cfg_data;
                CF_B1:   r_coef[CF_B1] <= i_cfg_data;
                CF_B2:   r_coef[CF_B2] <= i_cfg_data;
                CF_A1:   r_coef[CF_A1] <= i_cfg_data;
                CF_A2:   r_coef[CF_A2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdb_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_CHANS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ch),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_in.channel),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = {r_x, r_x1, r_y, r_y1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (ram_we) begin
            r_hist_vld[r_ch] <= 1'b1;
        end
    end

    always_comb begin
        mac_opnd = r_x;
        mac_neg  = 1'b0;
        case (r_tap)
            CF_B0:   mac_opnd = r_x;
            CF_B1:   mac_opnd = r_x1;
            CF_B2:   mac_opnd = r_x2;
            CF_A1: begin
                mac_opnd = r_y1;
                mac_neg  = 1'b1;
            end
            CF_A2: begin
                mac_opnd = r_y2;
                mac_neg  = 1'b1;
            end
            default: mac_opnd = r_x;
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    assign acc_rnd = r_acc + ACC_HALF;
    assign y_shift = acc_rnd[ACC_W-1:COEF_FRAC];

    always_comb begin
        if (!y_shift[YS_W-1] && (|y_shift[YS_W-2:SB-1])) begin
            y_sat = SAT_MAX;
        end else if (y_shift[YS_W-1] && !(&y_shift[YS_W-2:SB-1])) begin
            y_sat = SAT_MIN;
        end else begin
            y_sat = y_shift[SB-1:0];
        end
    end

    assign op_rnd  = r_oprod + OP_HALF;
    assign o_shift = op_rnd[OP_W-1:SCALE_SHIFT];

    always_comb begin
        if (!o_shift[OS_W-1] && (|o_shift[OS_W-2:SB-1])) begin
            o_sat = SAT_MAX;
        end else if (o_shift[OS_W-1] && !(&o_shift[OS_W-2:SB-1])) begin
            o_sat = SAT_MIN;
        end else begin
            o_sat = o_shift[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch     <= i_in.channel;
            r_x      <= i_in.sample_in;
            r_scale  <= i_in.out_scale;
            r_rd_vld <= r_hist_vld[i_in.channel];
        end
        if (r_state == ST_READ) begin
            r_tap <= CF_B0;
            if (r_rd_vld) begin
                r_x1 <= ram_rdata[4*SB-1:3*SB];
                r_x2 <= ram_rdata[3*SB-1:2*SB];
                r_y1 <= ram_rdata[2*SB-1:SB];
                r_y2 <= ram_rdata[SB-1:0];
            end else begin
                r_x1 <= '0;
                r_x2 <= '0;
                r_y1 <= '0;
                r_y2 <= '0;
            end
        end
        if (r_state == ST_MAC) begin
            r_prod     <= r_coef[r_tap] * mac_opnd;
            r_prod_neg <= mac_neg;
            r_tap      <= t_coef_idx'(r_tap + 1'b1);
            if (r_tap == CF_B0) begin
                r_acc <= '0;
            end
        end
        if (acc_add) begin
            r_acc <= r_prod_neg ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
        if (r_state == ST_ROUND) begin
            r_y <= y_sat;
        end
        if (r_state == ST_SCALE) begin
            r_oprod <= r_y * signed'({1'b0, r_scale});
        end
        if (out_load) begin
            r_out_ch     <= r_ch;
            r_out_sample <= o_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.channel_out = r_out_ch;
    assign o_out.sample_out  = r_out_sample;
endmodule
